### rtl/rsrd_pkg.sv
package rsrd_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [0:0] REG_BUFFER_CAPACITY = 1'b0;

   localparam logic [31:0] CAPACITY_RESET = 32'hFFFF_FFFF;
   localparam logic [31:0] PREFIX_WORD    = 32'h0000_0002;
   localparam logic [7:0]  RUN_BASE       = 8'h80;
   localparam logic [7:0]  TRANSPARENT    = 8'hFF;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_CODE    = 4'b0010,
      PH_LITERAL = 4'b0100,
      PH_IDLE    = 4'b1000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] position;
      logic [7:0]  pixel;
      logic [6:0]  run_length;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } result_type;

endpackage

### rtl/rsrd_csr.sv
module rsrd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsrd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rsrd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rsrd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [31:0]                         buffer_capacity
);
   import rsrd_pkg::*;

   logic [31:0] capacity_ff;
   logic [31:0] capacity_in;
   logic        hit;

   always_comb begin
      hit         = csr_paddr[CSR_ADDR_W-1:2] == REG_BUFFER_CAPACITY;
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         capacity_in = csr_pwdata;
      end
      csr_prdata = hit ? capacity_ff : '0;
   end

   assign csr_pready      = 1'b1;
   assign buffer_capacity = capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

### rtl/rsrd_decode.sv
module rsrd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_code_byte,
   input  logic                 req_start_of_image,
   input  logic [31:0]          buffer_capacity,
   input  logic                 queue_room,
   output logic [1:0]           push_count,
   output rsrd_pkg::result_type push_first,
   output rsrd_pkg::result_type push_second
);
   import rsrd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_soi_ff, in_soi_in;

   phase_type   phase_ff, phase_in;
   logic [23:0] hdr_ff, hdr_in;
   logic [1:0]  hdr_count_ff, hdr_count_in;
   logic        prefix_ff, prefix_in;
   logic [23:0] partial_ff, partial_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  literals_ff, literals_in;

   logic        fire;
   logic [7:0]  t;
   phase_type   phase_cur;
   logic [1:0]  count_cur;
   logic        prefix_cur;
   logic [15:0] width_new;
   logic [15:0] height_new;
   logic [23:0] product;
   logic [31:0] total_new;
   logic [7:0]  run_len;
   logic        is_run;
   logic        run_last;
   logic [6:0]  run_clip;
   logic [7:0]  literals_next;
   result_type  done_result;

   always_comb begin
      fire      = in_valid_ff && queue_room;
      req_ready = !in_valid_ff || fire;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_soi_in   = in_soi_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_code_byte;
         in_soi_in   = req_start_of_image;
      end

      t          = in_byte_ff;
      phase_cur  = in_soi_ff ? PH_HEADER : phase_ff;
      count_cur  = in_soi_ff ? 2'd0 : hdr_count_ff;
      prefix_cur = in_soi_ff ? 1'b0 : prefix_ff;

      width_new  = hdr_ff[15:0];
      height_new = {t, hdr_ff[23:16]};
      product    = width_new * t;
      total_new  = {8'd0, partial_ff} + {product, 8'd0};

      run_len  = t - RUN_BASE;
      is_run   = (t > RUN_BASE) && ({8'd0, run_len} <= width_ff);
      run_last = {25'd0, run_len[6:0]} >= remaining_ff;
      run_clip = run_last ? remaining_ff[6:0] : run_len[6:0];
      literals_next = literals_ff - 8'd1;

      done_result = '{kind: KIND_DONE, position: total_ff, pixel: 8'd0, run_length: 7'd0,
                      image_width: width_ff, image_height: height_ff};

      phase_in     = phase_ff;
      hdr_in       = hdr_ff;
      hdr_count_in = hdr_count_ff;
      prefix_in    = prefix_ff;
      partial_in   = partial_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      remaining_in = remaining_ff;
      literals_in  = literals_ff;
      push_count   = 2'd0;
      push_first   = '0;
      push_second  = '0;

      if (fire) begin
         phase_in     = phase_cur;
         hdr_count_in = count_cur;
         prefix_in    = prefix_cur;
         case (phase_cur)
            PH_HEADER: begin
               hdr_count_in = count_cur + 2'd1;
               case (count_cur)
                  2'd0: begin
                     hdr_in[7:0] = t;
                  end
                  2'd1: begin
                     hdr_in[15:8] = t;
                  end
                  2'd2: begin
                     hdr_in[23:16] = t;
                     partial_in    = product;
                  end
                  default: begin
                     prefix_in = 1'b1;
                     if (prefix_cur || ({t, hdr_ff} != PREFIX_WORD)) begin
                        width_in     = width_new;
                        height_in    = height_new;
                        total_in     = total_new;
                        pos_in       = '0;
                        remaining_in = total_new;
                        if (total_new > buffer_capacity) begin
                           push_count = 2'd1;
                           push_first = '{kind: KIND_ERROR, position: 32'd0, pixel: 8'd0,
                                          run_length: 7'd0, image_width: width_new,
                                          image_height: height_new};
                           phase_in   = PH_IDLE;
                        end else if (total_new == 32'd0) begin
                           push_count = 2'd1;
                           push_first = '{kind: KIND_DONE, position: 32'd0, pixel: 8'd0,
                                          run_length: 7'd0, image_width: width_new,
                                          image_height: height_new};
                           phase_in   = PH_IDLE;
                        end else begin
                           phase_in = PH_CODE;
                        end
                     end
                  end
               endcase
            end
            PH_CODE: begin
               if (is_run) begin
                  push_count   = 2'd1;
                  push_first   = '{kind: KIND_RUN, position: pos_ff, pixel: TRANSPARENT,
                                   run_length: run_clip, image_width: 16'd0,
                                   image_height: 16'd0};
                  pos_in       = pos_ff + {25'd0, run_clip};
                  remaining_in = remaining_ff - {25'd0, run_clip};
                  if (run_last) begin
                     push_count  = 2'd2;
                     push_second = done_result;
                     phase_in    = PH_IDLE;
                  end
               end else if (t != 8'd0) begin
                  literals_in = t;
                  phase_in    = PH_LITERAL;
               end
            end
            PH_LITERAL: begin
               if (remaining_ff != 32'd0) begin
                  push_count   = 2'd1;
                  push_first   = '{kind: KIND_WRITE, position: pos_ff, pixel: t,
                                   run_length: 7'd0, image_width: 16'd0,
                                   image_height: 16'd0};
                  pos_in       = pos_ff + 32'd1;
                  remaining_in = remaining_ff - 32'd1;
                  if (remaining_ff == 32'd1) begin
                     push_count  = 2'd2;
                     push_second = done_result;
                  end
               end
               literals_in = literals_next;
               if (literals_next == 8'd0) begin
                  phase_in = (remaining_ff <= 32'd1) ? PH_IDLE : PH_CODE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= 2'd0;
         prefix_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         prefix_ff    <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_soi_ff    <= in_soi_in;
      hdr_ff       <= hdr_in;
      partial_ff   <= partial_in;
      width_ff     <= width_in;
      height_ff    <= height_in;
      total_ff     <= total_in;
      pos_ff       <= pos_in;
      remaining_ff <= remaining_in;
      literals_ff  <= literals_in;
   end

endmodule

### rtl/rsrd_result_queue.sv
module rsrd_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  rsrd_pkg::result_type push_first,
   input  rsrd_pkg::result_type push_second,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsrd_pkg::result_type out_result
);
   import rsrd_pkg::*;

   result_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   tail_next;
   logic                pop;

   always_comb begin
      out_valid  = count_ff != '0;
      room       = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
      pop        = out_valid && out_ready;
      out_result = mem_ff[head_ff];
      tail_next  = tail_ff + QPTR_W'(1);
      head_in    = pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in    = tail_ff + QPTR_W'(push_count);
      count_in   = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[tail_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem_ff[tail_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/sprite_skip_rle_decoder.sv
// Decodes a transparent-skip RLE sprite, one stream word per cycle on the req channel while
// the result queue has room, into pixel-write, transparent-run, done and error words on the
// rsp channel. An accepted word is held in an input register and decoded from it, once the
// queue has room, into a four-entry result queue; each result is registered in the queue
// before it shows on rsp. A word that ends the image with a run or a literal yields two
// results, and a word is decoded only while two queue entries are free.
// The buffer capacity register sits at byte address 0 of the csr port.
module sprite_skip_rle_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_start_of_image,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rsrd_pkg::kind_type                  rsp_kind,
   output logic [31:0]                         rsp_position,
   output logic [7:0]                          rsp_pixel,
   output logic [6:0]                          rsp_run_length,
   output logic [15:0]                         rsp_image_width,
   output logic [15:0]                         rsp_image_height,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsrd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rsrd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rsrd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import rsrd_pkg::*;

   logic [31:0] buffer_capacity;
   logic        queue_room;
   logic [1:0]  push_count;
   result_type  push_first;
   result_type  push_second;
   result_type  out_result;

   rsrd_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .buffer_capacity (buffer_capacity)
   );

   rsrd_decode u_decode (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_byte      (req_code_byte),
      .req_start_of_image (req_start_of_image),
      .buffer_capacity    (buffer_capacity),
      .queue_room         (queue_room),
      .push_count         (push_count),
      .push_first         (push_first),
      .push_second        (push_second)
   );

   rsrd_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .room        (queue_room),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_result  (out_result)
   );

   assign rsp_kind         = out_result.kind;
   assign rsp_position     = out_result.position;
   assign rsp_pixel        = out_result.pixel;
   assign rsp_run_length   = out_result.run_length;
   assign rsp_image_width  = out_result.image_width;
   assign rsp_image_height = out_result.image_height;

endmodule

### rtl/rsrd_checker.sv
module rsrd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input rsrd_pkg::kind_type                  rsp_kind,
   input logic [31:0]                         rsp_position,
   input logic [7:0]                          rsp_pixel,
   input logic [6:0]                          rsp_run_length,
   input logic [15:0]                         rsp_image_width,
   input logic [15:0]                         rsp_image_height,
   input logic                                csr_pready
);
   import rsrd_pkg::*;

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_position)
         && $stable(rsp_pixel) && $stable(rsp_run_length))
      else $error("rsp word changed while stalled");

   a_run_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> rsp_pixel == TRANSPARENT
         && rsp_run_length != 7'd0 && rsp_image_width == 16'd0 && rsp_image_height == 16'd0)
      else $error("malformed run word");

   a_write_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WRITE |-> rsp_run_length == 7'd0
         && rsp_image_width == 16'd0 && rsp_image_height == 16'd0)
      else $error("malformed write word");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_position == 32'd0
         && rsp_pixel == 8'd0 && rsp_run_length == 7'd0)
      else $error("malformed error word");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr port not ready");

endmodule

bind sprite_skip_rle_decoder rsrd_checker u_checker (.*);
